// File: sv/pdist_pkg.sv
// Package for the pairwise point distance block: widths, codes and defaults.
package pdist_pkg;

  // Default store geometry
  localparam int MAX_POINTS_DEF  = 64;
  localparam int MAX_DIM_DEF     = 8;
  localparam int COORD_WIDTH_DEF = 16;

  // Input beat fields
  localparam int PIDX_W      = 6;
  localparam int CIDX_W      = 3;
  localparam int CVAL_W      = 16;
  localparam int IN_TDATA_W  = 32;

  // Result beat fields
  localparam int DIST_W      = 26;
  localparam int OUT_TDATA_W = 32;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Configuration registers
  localparam int MODE_W   = 2;
  localparam int DIMCNT_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 1'b1;
  localparam logic [MODE_W-1:0]    NORM_EUCLID   = 2'd0;
  localparam logic [MODE_W-1:0]    NORM_MAX      = 2'd1;
  localparam logic [MODE_W-1:0]    NORM_L1       = 2'd2;
  localparam logic [DIMCNT_W-1:0]  DIMCNT_RST    = 4'd8;

  // Request kinds carried in tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Squared sum and square root
  localparam int SQ_IN_W = 18;                        // larger differences saturate
  localparam int PROD_W  = 2 * SQ_IN_W;
  localparam int SQ_W    = PROD_W + 1;
  localparam logic [SQ_W-1:0] SQ_CAP = {1'b1, {PROD_W{1'b0}}};
  localparam int FRAC_W     = 8;
  localparam int RAD_W      = PROD_W + 2 * FRAC_W;    // radicand after the fraction shift
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

endpackage

// File: sv/pairwise_point_distance.sv
// Top level of the pairwise point distance block: coordinate store and norm sequencer.
// Load beat: one per cycle while idle, written to the coordinate RAM at the accepting edge.
// Query beat: per dimension S_RDB, S_DIFF, S_SQR and S_ACC, then the S_PREP setup,
//   26 square-root steps in S_ROOT (Euclidean only), then S_OUT loads the output register
//   once it is free, waiting out any result stall; the next beat waits for S_IDLE.
// Reset: control registers clear at once; datapath registers and coordinate RAM do not.
module pairwise_point_distance
  import pdist_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [5:0] point_index, [8:6] coord_index, [24:9] coord_value, [30:25] other_index
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                   s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [25:0] distance
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int DEPTH = MAX_POINTS * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNW   = $clog2(MAX_DIM + 1);
  localparam int IW    = (CW > CVAL_W) ? CW : CVAL_W;
  localparam int EW    = ((CW > SQ_IN_W) ? CW : SQ_IN_W) + 1;
  localparam int LW    = CW + $clog2(MAX_DIM) + 1;
  localparam int VW    = (LW > DIST_W) ? LW : DIST_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RDB  = 8'b00000010,
    S_DIFF = 8'b00000100,
    S_SQR  = 8'b00001000,
    S_ACC  = 8'b00010000,
    S_PREP = 8'b00100000,
    S_ROOT = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_e;

  // Input beat fields
  logic [PIDX_W-1:0] in_pidx;
  logic [CIDX_W-1:0] in_cidx;
  logic [CVAL_W-1:0] in_cval;
  logic [PIDX_W-1:0] in_oidx;

  assign in_pidx = s_axis_tdata[PIDX_W-1:0];
  assign in_cidx = s_axis_tdata[PIDX_W+CIDX_W-1:PIDX_W];
  assign in_cval = s_axis_tdata[PIDX_W+CIDX_W+CVAL_W-1:PIDX_W+CIDX_W];
  assign in_oidx = s_axis_tdata[2*PIDX_W+CIDX_W+CVAL_W-1:PIDX_W+CIDX_W+CVAL_W];

  // Control state
  state_e               state_q, state_d;
  logic [MODE_W-1:0]    norm_mode_q;
  logic [DIMCNT_W-1:0]  dim_count_q;
  logic                 out_valid_q, out_valid_d;
  logic [CNW-1:0]       d_q, d_d;
  logic [CNW-1:0]       dims_q, dims_d;
  logic [STEP_W-1:0]    step_q, step_d;

  // Datapath registers
  logic [PIDX_W-1:0]    pa_q, pb_q;
  logic                 a_oob_q, b_oob_q;
  logic [CW-1:0]        a_q;
  logic [CW-1:0]        ad_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 big_q;
  logic [SQ_W-1:0]      sq_q, sq_d;
  logic [CW-1:0]        mx_q, mx_d;
  logic [LW-1:0]        l1_q, l1_d;
  logic [RAD_W-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic [DIST_W-1:0]    res_q, res_d;
  logic [DIST_W-1:0]    out_data_q;

  // Handshake and store signals
  logic                 in_acc;
  logic                 load_we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [CW-1:0]        wdata;
  logic [CW-1:0]        rdata;
  logic [IW-1:0]        cval_ext;
  logic [CNW-1:0]       dims_sat;
  logic                 out_free;

  // Arithmetic
  logic [CW-1:0]        b_val;
  logic [CW:0]          diff_ab, diff_ba;
  logic                 a_ge_b;
  logic [CW-1:0]        ad_d;
  logic [EW-1:0]        ad_ext;
  logic [SQ_W:0]        sq_sum;
  logic [VW-1:0]        sel_val;
  logic [REM_W+1:0]     rem_ext;
  logic [REM_W+1:0]     trial;

  function automatic logic [AW-1:0] coord_addr(input logic [PIDX_W-1:0] p,
                                               input logic [CNW-1:0] d);
    coord_addr = AW'(AW'(p) * AW'(MAX_DIM) + AW'(d));
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Load path: keep the low COORD_WIDTH bits, drop writes outside the store
  assign cval_ext = IW'(in_cval);
  assign wdata    = cval_ext[CW-1:0];
  assign waddr    = coord_addr(in_pidx, CNW'(in_cidx));
  assign load_we  = in_acc && (s_axis_tuser == REQ_LOAD)
                    && (32'(in_pidx) < 32'(MAX_POINTS)) && (32'(in_cidx) < 32'(MAX_DIM));

  assign dims_sat = (32'(dim_count_q) > 32'(MAX_DIM)) ? CNW'(MAX_DIM) : CNW'(dim_count_q);

  // Read address: first A read from the beat, then B, then next A
  always_comb begin
    case (state_q)
      S_RDB:   raddr = coord_addr(pb_q, d_q);
      S_ACC:   raddr = coord_addr(pa_q, d_q + CNW'(1));
      default: raddr = coord_addr(in_pidx, '0);
    endcase
  end

  pdist_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Absolute difference of the two coordinates
  assign b_val   = b_oob_q ? '0 : rdata;
  assign diff_ab = {a_q[CW-1], a_q} - {b_val[CW-1], b_val};
  assign diff_ba = {b_val[CW-1], b_val} - {a_q[CW-1], a_q};
  assign a_ge_b  = $signed(a_q) >= $signed(b_val);
  assign ad_d    = a_ge_b ? diff_ab[CW-1:0] : diff_ba[CW-1:0];
  assign ad_ext  = EW'(ad_q);

  // Accumulate squares with saturation at the cap
  assign sq_sum  = (SQ_W+1)'(sq_q) + (SQ_W+1)'(prod_q);

  // Max or L1 result, clamped to the result width
  assign sel_val = (norm_mode_q == NORM_MAX) ? VW'(mx_q) : VW'(l1_q);

  // One square-root digit: bring down two radicand bits, try the next root bit
  assign rem_ext = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign trial   = (REM_W+2)'({root_q, 2'b01});

  // Sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    d_d         = d_q;
    dims_d      = dims_q;
    step_d      = step_q;
    sq_d        = sq_q;
    mx_d        = mx_q;
    l1_d        = l1_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    res_d       = res_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == REQ_QUERY)) begin
          d_d    = '0;
          dims_d = dims_sat;
          sq_d   = '0;
          mx_d   = '0;
          l1_d   = '0;
          state_d = (dims_sat == '0) ? S_PREP : S_RDB;
        end
      end
      S_RDB: begin
        state_d = S_DIFF;
      end
      S_DIFF: begin
        state_d = S_SQR;
      end
      S_SQR: begin
        if (ad_q > mx_q) begin
          mx_d = ad_q;
        end
        l1_d    = l1_q + LW'(ad_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (big_q || (sq_sum > (SQ_W+1)'(SQ_CAP))) begin
          sq_d = SQ_CAP;
        end else begin
          sq_d = sq_sum[SQ_W-1:0];
        end
        d_d = d_q + CNW'(1);
        state_d = ((d_q + CNW'(1)) < dims_q) ? S_RDB : S_PREP;
      end
      S_PREP: begin
        if (norm_mode_q == NORM_EUCLID) begin
          if (sq_q >= SQ_CAP) begin
            res_d   = DIST_MAX;
            state_d = S_OUT;
          end else begin
            rad_d   = {sq_q[PROD_W-1:0], {(2*FRAC_W){1'b0}}};
            rem_d   = '0;
            root_d  = '0;
            step_d  = '0;
            state_d = S_ROOT;
          end
        end else begin
          res_d   = (sel_val > VW'(DIST_MAX)) ? DIST_MAX : sel_val[DIST_W-1:0];
          state_d = S_OUT;
        end
      end
      S_ROOT: begin
        rad_d = {rad_q[RAD_W-3:0], 2'b00};
        if (rem_ext >= trial) begin
          rem_d  = REM_W'(rem_ext - trial);
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_ext[REM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          res_d   = DIST_W'(root_d);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      norm_mode_q <= NORM_EUCLID;
      dim_count_q <= DIMCNT_RST;
      d_q         <= '0;
      dims_q      <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      d_q         <= d_d;
      dims_q      <= dims_d;
      step_q      <= step_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NORM_MODE: norm_mode_q <= cfg_wdata_i[MODE_W-1:0];
          CFG_DIM_COUNT: dim_count_q <= cfg_wdata_i[DIMCNT_W-1:0];
          default:       norm_mode_q <= norm_mode_q;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    mx_q   <= mx_d;
    l1_q   <= l1_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    res_q  <= res_d;
    if (in_acc) begin
      pa_q    <= in_pidx;
      pb_q    <= in_oidx;
      a_oob_q <= 32'(in_pidx) >= 32'(MAX_POINTS);
      b_oob_q <= 32'(in_oidx) >= 32'(MAX_POINTS);
    end
    if (state_q == S_RDB) begin
      a_q <= a_oob_q ? '0 : rdata;
    end
    if (state_q == S_DIFF) begin
      ad_q <= ad_d;
    end
    if (state_q == S_SQR) begin
      prod_q <= ad_ext[SQ_IN_W-1:0] * ad_ext[SQ_IN_W-1:0];
      big_q  <= ad_ext >= EW'(2 ** SQ_IN_W);
    end
    if ((state_q == S_OUT) && out_free) begin
      out_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

  // Hold a waiting result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !m_axis_tready) |=> (state_q == S_OUT))
    else $error("result overwritten while the output beat is stalled");

  // Square sum never passes the cap
  a_sq_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP) |-> (sq_q <= SQ_CAP))
    else $error("square sum above cap");

  // Root step counter stays within the digit count
  a_root_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT) |-> (step_q < STEP_W'(ROOT_STEPS)))
    else $error("square root ran past its last digit");

  // A load beat leaves the sequencer idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == REQ_LOAD) |=> (state_q == S_IDLE))
    else $error("load beat started a query sequence");

endmodule

// File: sv/pdist_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pdist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
